// File: design/zlhw_pkg.sv
package zlhw_pkg;

  localparam int HEADER_BYTES     = 26;
  localparam int DESCRIPTOR_BYTES = 12;
  localparam int DESCRIPTOR_BIT   = 3;
  localparam int FIFO_DEPTH       = 4;
  localparam int PTR_BITS         = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS         = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] METHOD_STORED = 16'h0000;
  localparam logic [23:0] SIG_HEAD       = 24'h504B03;
  localparam logic [7:0]  SIG_TAIL       = 8'h04;

  localparam logic [7:0] SIG_BYTES [4] = '{8'h50, 8'h4B, 8'h03, 8'h04};

  typedef enum logic [1:0] {
    KIND_NAME     = 2'd0,
    KIND_FOUND    = 2'd1,
    KIND_NOARCH   = 2'd2,
    KIND_ENDED    = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_SEARCH    = 6'b000001,
    PH_HEADER    = 6'b000010,
    PH_NAME      = 6'b000100,
    PH_SKIP      = 6'b001000,
    PH_SIGNATURE = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_byte;
    logic        name_last;
    logic        empty_name;
    logic [31:0] start_offset;
    logic        run_last;
  } res_t;

endpackage

// File: design/zip_local_header_walker_unit.sv
// ZIP local header walker.
// Input stream: one file byte per word on in_tdata, in_tlast on the final
// byte of the file. The block searches for the first local header signature,
// reports its offset (kind 1), then walks the chain of local headers and
// emits every entry name byte by byte (kind 0, name_last on the final name
// byte, empty_name for a zero-length name). The walk stops at the first bad
// signature. The final byte of a file adds a closing word: kind 2 when no
// signature was seen, else kind 3; the block is then ready for a new file.
// out_tlast marks the last result word caused by one input byte.
// Throughput: one byte per cycle while in_tready is high; a byte that causes
// two results writes two words. Results go into a four-word queue and
// in_tready is high while at least two entries are free, so the input keeps
// moving while the receiver holds a finished word; a long stall on out_tready
// fills the queue and then drops in_tready until words drain.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to
// the search state with the byte offset at zero.
module zip_local_header_walker_unit
  import zlhw_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] name_byte, [39:8] start_offset
  output logic [3:0]  out_tuser,  // [1:0] kind, [2] name_last, [3] empty_name
  output logic        out_tlast   // run_last
);

  phase_t                 phase_r, phase_nxt;
  logic [23:0]            window_r, window_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [4:0]             hidx_r, hidx_nxt;
  logic [15:0]            method_r, method_nxt;
  logic                   desc_r, desc_nxt;
  logic [31:0]            packed_r, packed_nxt;
  logic [31:0]            plain_r, plain_nxt;
  logic [15:0]            nlen_r, nlen_nxt;
  logic [15:0]            xlen_r, xlen_nxt;
  logic [33:0]            skip_r, skip_nxt;
  logic [15:0]            ncnt_r, ncnt_nxt;

  res_t                   fifo_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]    count_r;

  logic                   accept, pop;
  logic [7:0]             b;
  logic                   have_body;
  res_t                   body, res0, res1, end_res;
  logic [1:0]             n_res;
  logic [OFFSET_BITS-1:0] off_pos;
  logic [OFFSET_BITS+31:0] off_ext;
  logic [33:0]            skip_sum;
  logic [15:0]            ncnt_inc;
  logic [33:0]            skip_dec;

  assign accept    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;
  assign in_tready = (count_r <= CNT_BITS'(FIFO_DEPTH - 2));
  assign b         = in_tdata;

  assign off_pos  = pos_r - OFFSET_BITS'(3);
  assign off_ext  = {32'd0, off_pos};
  assign ncnt_inc = ncnt_r + 16'd1;
  assign skip_dec = skip_r - 34'd1;
  // extra length high byte arrives with the final header byte
  assign skip_sum = 34'({b, xlen_r[7:0]})
                  + ((method_r == METHOD_STORED) ? 34'(plain_r) : 34'(packed_r))
                  + (desc_r ? 34'(DESCRIPTOR_BYTES) : 34'd0);

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    hidx_nxt   = hidx_r;
    method_nxt = method_r;
    desc_nxt   = desc_r;
    packed_nxt = packed_r;
    plain_nxt  = plain_r;
    nlen_nxt   = nlen_r;
    xlen_nxt   = xlen_r;
    skip_nxt   = skip_r;
    ncnt_nxt   = ncnt_r;
    pos_nxt    = pos_r + OFFSET_BITS'(1);
    have_body  = 1'b0;
    body       = '0;
    body.kind  = KIND_NAME;

    case (phase_r)
      PH_SEARCH: begin
        if (b == SIG_TAIL && window_r == SIG_HEAD) begin
          have_body         = 1'b1;
          body.kind         = KIND_FOUND;
          body.start_offset = off_ext[31:0];
          phase_nxt  = PH_HEADER;
          hidx_nxt   = '0;
          method_nxt = '0;
          desc_nxt   = 1'b0;
          packed_nxt = '0;
          plain_nxt  = '0;
          nlen_nxt   = '0;
          xlen_nxt   = '0;
        end
        window_nxt = {window_r[15:0], b};
      end
      PH_HEADER: begin
        case (hidx_r)
          5'd2:  desc_nxt           = b[DESCRIPTOR_BIT];
          5'd4:  method_nxt[7:0]    = b;
          5'd5:  method_nxt[15:8]   = b;
          5'd14: packed_nxt[7:0]    = b;
          5'd15: packed_nxt[15:8]   = b;
          5'd16: packed_nxt[23:16]  = b;
          5'd17: packed_nxt[31:24]  = b;
          5'd18: plain_nxt[7:0]     = b;
          5'd19: plain_nxt[15:8]    = b;
          5'd20: plain_nxt[23:16]   = b;
          5'd21: plain_nxt[31:24]   = b;
          5'd22: nlen_nxt[7:0]      = b;
          5'd23: nlen_nxt[15:8]     = b;
          5'd24: xlen_nxt[7:0]      = b;
          5'd25: xlen_nxt[15:8]     = b;
          default: ;
        endcase
        hidx_nxt = hidx_r + 5'd1;
        if (hidx_r == 5'(HEADER_BYTES - 1)) begin
          skip_nxt = skip_sum;
          if (nlen_r == 16'd0) begin
            have_body       = 1'b1;
            body.name_last  = 1'b1;
            body.empty_name = 1'b1;
            if (skip_sum == 34'd0) begin
              phase_nxt = PH_SIGNATURE;
              hidx_nxt  = '0;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else begin
            phase_nxt = PH_NAME;
            ncnt_nxt  = '0;
          end
        end
      end
      PH_NAME: begin
        ncnt_nxt       = ncnt_inc;
        have_body      = 1'b1;
        body.name_byte = b;
        if (ncnt_inc == nlen_r) begin
          body.name_last = 1'b1;
          if (skip_r == 34'd0) begin
            phase_nxt = PH_SIGNATURE;
            hidx_nxt  = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 34'd0) begin
          phase_nxt = PH_SIGNATURE;
          hidx_nxt  = '0;
        end
      end
      PH_SIGNATURE: begin
        if (b != SIG_BYTES[hidx_r[1:0]]) begin
          phase_nxt = PH_DONE;
        end else begin
          hidx_nxt = hidx_r + 5'd1;
          if (hidx_r == 5'd3) begin
            phase_nxt  = PH_HEADER;
            hidx_nxt   = '0;
            method_nxt = '0;
            desc_nxt   = 1'b0;
            packed_nxt = '0;
            plain_nxt  = '0;
            nlen_nxt   = '0;
            xlen_nxt   = '0;
          end
        end
      end
      default: ;
    endcase

    end_res          = '0;
    end_res.kind     = (phase_nxt == PH_SEARCH) ? KIND_NOARCH : KIND_ENDED;
    end_res.run_last = 1'b1;

    res0 = body;
    res1 = end_res;
    if (in_tlast) begin
      if (have_body) begin
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
        res0  = end_res;
      end
      // back to the reset state for the next file
      phase_nxt  = PH_SEARCH;
      window_nxt = '0;
      pos_nxt    = '0;
      hidx_nxt   = '0;
      method_nxt = '0;
      desc_nxt   = 1'b0;
      packed_nxt = '0;
      plain_nxt  = '0;
      nlen_nxt   = '0;
      xlen_nxt   = '0;
      skip_nxt   = '0;
      ncnt_nxt   = '0;
    end else begin
      n_res         = have_body ? 2'd1 : 2'd0;
      res0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      window_r <= '0;
      pos_r    <= '0;
      hidx_r   <= '0;
      method_r <= '0;
      desc_r   <= 1'b0;
      packed_r <= '0;
      plain_r  <= '0;
      nlen_r   <= '0;
      xlen_r   <= '0;
      skip_r   <= '0;
      ncnt_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      pos_r    <= pos_nxt;
      hidx_r   <= hidx_nxt;
      method_r <= method_nxt;
      desc_r   <= desc_nxt;
      packed_r <= packed_nxt;
      plain_r  <= plain_nxt;
      nlen_r   <= nlen_nxt;
      xlen_r   <= xlen_nxt;
      skip_r   <= skip_nxt;
      ncnt_r   <= ncnt_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_BITS'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + PTR_BITS'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      end
      count_r <= count_r + (accept ? CNT_BITS'(n_res) : CNT_BITS'(0))
                         - (pop ? CNT_BITS'(1) : CNT_BITS'(0));
    end
  end

  res_t head;
  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {head.start_offset, head.name_byte};
  assign out_tuser  = {head.empty_name, head.name_last, head.kind};
  assign out_tlast  = head.run_last;

endmodule

// File: design/zlhw_checker.sv
module zlhw_checker
  import zlhw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_offset_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != KIND_FOUND |-> out_tdata[39:8] == 32'd0)
    else $error("start offset set on a word that is not archive found");

  a_empty_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |->
      out_tuser[2] && out_tuser[1:0] == KIND_NAME && out_tdata[7:0] == 8'd0)
    else $error("empty name word malformed");

  a_flags_on_name_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != KIND_NAME |-> out_tuser[3:2] == 2'b00)
    else $error("name flags set on a status word");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == KIND_NOARCH || out_tuser[1:0] == KIND_ENDED)
      |-> out_tlast)
    else $error("end of file word not marked last");

endmodule

bind zip_local_header_walker_unit zlhw_checker u_zlhw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: verif/header_walk_checker.sv
module header_walk_checker
  import zlhw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  output int          faults,
  output int          waiting,
  output int          words_checked
);

  localparam logic [31:0] SIG_WORD = {SIG_HEAD, SIG_TAIL};

  // shadow of the walker
  logic [23:0] window;
  phase_t      walk_phase;
  logic [31:0] offset;
  logic [4:0]  hdr_idx;
  logic [15:0] method;
  logic [15:0] name_len;
  logic [15:0] extra_len;
  logic [15:0] name_seen;
  logic        desc_flag;
  logic [31:0] packed_sz;
  logic [31:0] plain_sz;
  logic [33:0] skip_left;

  res_t awaited_results[$];

  task automatic report_fault(input string msg);
    $display("checker: word %0d: %s", words_checked, msg);
    faults++;
  endtask

  task automatic open_header();
    walk_phase = PH_HEADER;
    hdr_idx    = '0;
    method     = '0;
    desc_flag  = 1'b0;
    packed_sz  = '0;
    plain_sz   = '0;
    name_len   = '0;
    extra_len  = '0;
  endtask

  task automatic clear_walk();
    open_header();
    walk_phase = PH_SEARCH;
    window     = '0;
    offset     = '0;
    skip_left  = '0;
    name_seen  = '0;
  endtask

  task automatic leave_name();
    if (skip_left == '0) begin
      walk_phase = PH_SIGNATURE;
      hdr_idx    = '0;
    end else begin
      walk_phase = PH_SKIP;
    end
  endtask

  task automatic push_word(input kind_t k, input logic [7:0] nb, input logic nl,
                           input logic en, input logic [31:0] off);
    res_t w;
    w.kind         = k;
    w.name_byte    = nb;
    w.name_last    = nl;
    w.empty_name   = en;
    w.start_offset = off;
    w.run_last     = 1'b0;
    awaited_results.push_back(w);
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic fin);
    int first_new;
    int i;
    first_new = awaited_results.size();
    case (walk_phase)
      PH_SEARCH: begin
        if (b == SIG_TAIL && window == SIG_HEAD) begin
          push_word(KIND_FOUND, 8'h00, 1'b0, 1'b0, offset - 32'd3);
          open_header();
        end
        window = {window[15:0], b};
      end
      PH_HEADER: begin
        i = int'(hdr_idx);
        if (i == 2) desc_flag = b[DESCRIPTOR_BIT];
        else if (i == 4 || i == 5) method[8*(i-4) +: 8] = b;
        else if (i >= 14 && i <= 17) packed_sz[8*(i-14) +: 8] = b;
        else if (i >= 18 && i <= 21) plain_sz[8*(i-18) +: 8] = b;
        else if (i == 22 || i == 23) name_len[8*(i-22) +: 8] = b;
        else if (i == 24 || i == 25) extra_len[8*(i-24) +: 8] = b;
        hdr_idx = hdr_idx + 5'd1;
        if (hdr_idx >= HEADER_BYTES) begin
          skip_left = 34'(extra_len)
                    + 34'((method == METHOD_STORED) ? plain_sz : packed_sz)
                    + (desc_flag ? 34'(DESCRIPTOR_BYTES) : 34'd0);
          if (name_len == '0) begin
            push_word(KIND_NAME, 8'h00, 1'b1, 1'b1, '0);
            leave_name();
          end else begin
            walk_phase = PH_NAME;
            name_seen  = '0;
          end
        end
      end
      PH_NAME: begin
        name_seen = name_seen + 16'd1;
        push_word(KIND_NAME, b, name_seen == name_len, 1'b0, '0);
        if (name_seen == name_len) leave_name();
      end
      PH_SKIP: begin
        skip_left = skip_left - 34'd1;
        if (skip_left == '0) begin
          walk_phase = PH_SIGNATURE;
          hdr_idx    = '0;
        end
      end
      PH_SIGNATURE: begin
        // stop the walk on the first byte off the signature
        if (b != SIG_WORD[8*(3-hdr_idx[1:0]) +: 8]) begin
          walk_phase = PH_DONE;
        end else begin
          hdr_idx = hdr_idx + 5'd1;
          if (hdr_idx >= 5'd4) open_header();
        end
      end
      default: ;
    endcase
    offset = offset + 32'd1;
    if (fin) begin
      push_word((walk_phase == PH_SEARCH) ? KIND_NOARCH : KIND_ENDED,
                8'h00, 1'b0, 1'b0, '0);
      clear_walk();
    end
    if (awaited_results.size() > first_new)
      awaited_results[awaited_results.size()-1].run_last = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      clear_walk();
      awaited_results.delete();
    end else begin
      // compare first: a byte taken now only shows up on a later edge
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_fault($sformatf("unexpected word tdata=%h tuser=%h tlast=%b",
                                 out_tdata, out_tuser, out_tlast));
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser[1:0] !== want.kind)
            report_fault($sformatf("kind %0d, want %0d", out_tuser[1:0], want.kind));
          if (out_tdata[7:0] !== want.name_byte)
            report_fault($sformatf("name_byte %h, want %h", out_tdata[7:0],
                                   want.name_byte));
          if (out_tuser[2] !== want.name_last)
            report_fault($sformatf("name_last %b, want %b", out_tuser[2],
                                   want.name_last));
          if (out_tuser[3] !== want.empty_name)
            report_fault($sformatf("empty_name %b, want %b", out_tuser[3],
                                   want.empty_name));
          if (out_tdata[39:8] !== want.start_offset)
            report_fault($sformatf("start_offset %0d, want %0d", out_tdata[39:8],
                                   want.start_offset));
          if (out_tlast !== want.run_last)
            report_fault($sformatf("run_last %b, want %b", out_tlast, want.run_last));
          words_checked++;
        end
      end
      if (in_tvalid && in_tready) walk_byte(in_tdata, in_tlast);
    end
    waiting <= awaited_results.size();
  end

endmodule

// File: verif/tb.sv
module tb;
  import zlhw_pkg::*;

  localparam int          LIMIT    = 400000;
  localparam int          RANDOM_BYTES = 400;
  localparam logic [31:0] SIG_WORD = {SIG_HEAD, SIG_TAIL};

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  int faults;
  int waiting;
  int words_checked;
  int cycles;
  int bytes_sent;
  int files_sent;
  int stall_left;
  bit calm;

  logic [7:0] file_bytes[$];

  zip_local_header_walker_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  header_walk_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .faults        (faults),
    .waiting       (waiting),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver: stall out_tready in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic add_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic add_sig();
    for (int j = 0; j < 4; j++) file_bytes.push_back(SIG_WORD[8*(3-j) +: 8]);
  endtask

  task automatic add_random(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  // one local header; a broken one carries full-width fields and a short body
  task automatic add_entry(input bit whole);
    logic [15:0] flags;
    logic [15:0] method;
    logic [15:0] name_len;
    logic [15:0] extra_len;
    logic [31:0] packed_sz;
    logic [31:0] plain_sz;
    int          body;
    flags     = 16'($urandom);
    method    = ($urandom_range(0, 1) == 0) ? METHOD_STORED : 16'($urandom);
    packed_sz = $urandom;
    plain_sz  = $urandom;
    name_len  = 16'($urandom);
    extra_len = 16'($urandom);
    if (whole) begin
      name_len  = 16'($urandom_range(0, 4));
      extra_len = 16'($urandom_range(0, 3));
      flags[DESCRIPTOR_BIT] = ($urandom_range(0, 3) == 0);
      if (method == METHOD_STORED) plain_sz = $urandom_range(0, 6);
      else packed_sz = $urandom_range(0, 6);
    end
    add_sig();
    add_le($urandom, 2);
    add_le(32'(flags), 2);
    add_le(32'(method), 2);
    add_le($urandom, 4);
    add_le($urandom, 4);
    add_le(packed_sz, 4);
    add_le(plain_sz, 4);
    add_le(32'(name_len), 2);
    add_le(32'(extra_len), 2);
    if (whole) begin
      body = name_len + extra_len + ((method == METHOD_STORED) ? plain_sz : packed_sz)
           + (flags[DESCRIPTOR_BIT] ? DESCRIPTOR_BYTES : 0);
      add_random(body);
    end else begin
      add_random($urandom_range(0, 8));
    end
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (!calm && $urandom_range(0, 6) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= file_bytes[i];
      in_tlast  <= (i == file_bytes.size() - 1);
      do @(posedge clk); while (!in_tready);
    end
    bytes_sent += file_bytes.size();
    files_sent++;
    file_bytes.delete();
  endtask

  initial begin : stimulus
    int counted;
    int pick;
    int tail;
    int k;
    counted = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single byte, no signature anywhere
    file_bytes.push_back(8'hFF);
    send_file();
    // signature closes the file: found and ended from one byte
    file_bytes.push_back(8'h00);
    add_sig();
    send_file();
    // empty name, zero skip; flag bits other than bit 3 set
    add_sig();
    add_le(32'h0000FFFF, 2);
    add_le(32'h0000FFF7, 2);
    add_le(32'h00000008, 2);
    add_le(32'hFFFFFFFF, 4);
    add_le(32'hFFFFFFFF, 4);
    add_le(32'h00000000, 4);
    add_le(32'hFFFFFFFF, 4);
    add_le(32'h00000000, 2);
    add_le(32'h00000000, 2);
    send_file();

    while (counted < RANDOM_BYTES) begin
      if (counted >= RANDOM_BYTES - 70) calm <= 1'b1;
      tail = 0;
      pick = $urandom_range(0, 15);
      if (pick > 1)
        add_random(($urandom_range(0, 7) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3));
      case (pick)
        0, 1: begin
          // noise rich in signature fragments
          repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 4))
              0: file_bytes.push_back(SIG_WORD[31:24]);
              1: file_bytes.push_back(SIG_WORD[23:16]);
              2: file_bytes.push_back(SIG_WORD[15:8]);
              3: file_bytes.push_back(SIG_WORD[7:0]);
              default: file_bytes.push_back(8'($urandom));
            endcase
          end
        end
        2: begin
          repeat ($urandom_range(1, 2)) add_entry(1'b1);
          k = $urandom_range(0, 3);
          for (int j = 0; j < k; j++) file_bytes.push_back(SIG_WORD[8*(3-j) +: 8]);
          file_bytes.push_back(SIG_WORD[8*(3-k) +: 8] ^ 8'($urandom_range(1, 255)));
          tail = $urandom_range(0, 6);
          add_random(tail);
        end
        3: begin
          repeat ($urandom_range(0, 2)) add_entry(1'b1);
          add_entry(1'b0);
        end
        4: begin
          repeat ($urandom_range(1, 2)) add_entry(1'b1);
          repeat ($urandom_range(1, file_bytes.size() - 1)) void'(file_bytes.pop_back());
        end
        default: repeat ($urandom_range(1, 3)) add_entry(1'b1);
      endcase
      counted += file_bytes.size() - tail;
      send_file();
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d files, %0d bytes (directed edge cases, well-formed, broken and",
             files_sent, bytes_sent);
    $display("truncated archives, signature noise); compared %0d result words",
             words_checked);
    if (faults == 0 && waiting == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/zlhw_pkg.sv
design/zip_local_header_walker_unit.sv
design/zlhw_checker.sv
verif/header_walk_checker.sv
verif/tb.sv
